[hdl/mcc_pkg.sv]
package mcc_pkg;

    localparam int SCALE_W   = 16;
    localparam int LVL_W     = 10;
    localparam int MUL_W     = 16;
    localparam int QUO_W     = 11;
    // scale << QUO_W must fit
    localparam int SUB_W     = SCALE_W + QUO_W;
    localparam int CFG_IDX_W = 1;

    localparam logic [LVL_W-1:0]   LVL_MAX         = 10'd1000;
    localparam logic [SCALE_W-1:0] MOTION_SCALE_RST = 16'd4176;
    localparam logic [SCALE_W-1:0] BUMP_SCALE_RST   = 16'd6683;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MOTION_SCALE = 1'b0,
        REG_BUMP_SCALE   = 1'b1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        PET_UNKNOWN = 2'd0,
        PET_CALM    = 2'd1,
        PET_ACTIVE  = 2'd2,
        PET_ANXIOUS = 2'd3
    } pet_t;

    typedef enum logic [1:0] {
        RISK_NORMAL  = 2'd0,
        RISK_WARNING = 2'd1,
        RISK_DANGER  = 2'd2
    } risk_t;

    typedef enum logic [2:0] {
        MSG_UNAVAILABLE = 3'd0,
        MSG_TEMP_UNSAFE = 3'd1,
        MSG_TEMP_HIGH   = 3'd2,
        MSG_BUMPS       = 3'd3,
        MSG_ACTIVITY    = 3'd4,
        MSG_COMFORTABLE = 3'd5
    } msg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ_X,
        ST_SQ_Y,
        ST_SQ_Z,
        ST_SQRT,
        ST_DELTA,
        ST_CLOSE,
        ST_LV_MUL,
        ST_LV_PRE,
        ST_LV_DIV,
        ST_LV_DONE,
        ST_SMOOTH,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic               sample_valid;
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
        logic               burst_end;
        logic               motion_ok;
        logic               env_ok;
        logic signed [11:0] temperature;
        logic [9:0]         humidity;
    } in_item_t;

    typedef struct packed {
        logic [LVL_W-1:0] motion_level;
        logic [LVL_W-1:0] bump_level;
        logic [6:0]       comfort_score;
        pet_t             pet_status;
        risk_t            risk_level;
        msg_t             message_code;
    } out_item_t;

    typedef struct packed {
        logic [MUL_W-1:0] mul_a;
        logic [MUL_W-1:0] mul_b;
        logic [SUB_W-1:0] sub_a;
        logic [SUB_W-1:0] sub_b;
    } alu_req_t;

    typedef struct packed {
        logic [2*MUL_W-1:0] prod;
        logic [SUB_W-1:0]   diff;
        logic               ge;
    } alu_res_t;

    typedef struct packed {
        logic               motion_ok;
        logic               env_ok;
        logic signed [11:0] temperature;
        logic [9:0]         humidity;
        logic [LVL_W-1:0]   motion;
        logic [LVL_W-1:0]   bump;
    } cls_in_t;

endpackage

[hdl/mcc_if.sv]
interface mcc_sample_if;
    logic              valid;
    logic              ready;
    mcc_pkg::in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface mcc_result_if;
    logic               valid;
    logic               ready;
    mcc_pkg::out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface mcc_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [mcc_pkg::CFG_IDX_W-1:0]  index;
    logic [mcc_pkg::SCALE_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[hdl/mcc_alu.sv]
// Shared arithmetic unit: one unsigned multiplier and one subtract/compare.
module mcc_alu (
    input  mcc_pkg::alu_req_t req,
    output mcc_pkg::alu_res_t res
);

    logic [mcc_pkg::SUB_W:0] sub_full;

    always_comb
    begin
        sub_full = {1'b0, req.sub_a} - {1'b0, req.sub_b};
        res.prod = (2*mcc_pkg::MUL_W)'(req.mul_a) * (2*mcc_pkg::MUL_W)'(req.mul_b);
        res.diff = sub_full[mcc_pkg::SUB_W-1:0];
        res.ge   = ~sub_full[mcc_pkg::SUB_W];
    end

endmodule

[hdl/mcc_classify.sv]
// Threshold scoring of one closed burst.
module mcc_classify (
    input  mcc_pkg::cls_in_t   cin,
    output mcc_pkg::out_item_t cout
);

    localparam logic signed [11:0] TEMP_DANGER = 12'sd340;
    localparam logic signed [11:0] TEMP_HOT    = 12'sd300;
    localparam logic signed [11:0] TEMP_WARM   = 12'sd260;
    localparam logic signed [11:0] TEMP_COOL   = 12'sd180;
    localparam logic signed [11:0] TEMP_COLD   = 12'sd100;
    localparam logic [9:0]  HUM_HIGH   = 10'd750;
    localparam logic [9:0]  HUM_DAMP   = 10'd650;
    localparam logic [9:0]  HUM_DRY    = 10'd300;
    localparam logic [mcc_pkg::LVL_W-1:0] BUMP_HARD   = 10'd550;
    localparam logic [mcc_pkg::LVL_W-1:0] BUMP_SOFT   = 10'd250;
    localparam logic [mcc_pkg::LVL_W-1:0] MOTION_HIGH = 10'd600;
    localparam logic [mcc_pkg::LVL_W-1:0] MOTION_MID  = 10'd300;
    localparam logic [mcc_pkg::LVL_W-1:0] CALM_MAX    = 10'd250;
    localparam logic [6:0]  SCORE_DANGER = 7'd50;
    localparam logic [6:0]  SCORE_WARN   = 7'd70;

    logic signed [11:0] temp;
    logic signed [7:0]  score_s;
    logic [6:0]         score;
    logic               temp_danger;
    logic               temp_hot;
    logic               hum_high;
    logic               bump_hard;

    always_comb
    begin
        temp        = $signed(cin.temperature);
        temp_danger = temp > TEMP_DANGER;
        temp_hot    = temp > TEMP_HOT;
        hum_high    = cin.humidity > HUM_HIGH;
        bump_hard   = cin.bump > BUMP_HARD;

        score_s = 8'sd100;
        if (temp_danger)
            score_s = score_s - 8'sd45;
        else if (temp >= TEMP_HOT)
            score_s = score_s - 8'sd25;
        else if (temp >= TEMP_WARM)
            score_s = score_s - 8'sd10;
        else if (temp < TEMP_COLD)
            score_s = score_s - 8'sd30;
        else if (temp < TEMP_COOL)
            score_s = score_s - 8'sd10;

        if (hum_high)
            score_s = score_s - 8'sd20;
        else if (cin.humidity > HUM_DAMP)
            score_s = score_s - 8'sd10;
        else if (cin.humidity < HUM_DRY)
            score_s = score_s - 8'sd10;

        if (bump_hard)
            score_s = score_s - 8'sd25;
        else if (cin.bump >= BUMP_SOFT)
            score_s = score_s - 8'sd10;

        if (cin.motion > MOTION_HIGH)
            score_s = score_s - 8'sd15;
        else if (cin.motion >= MOTION_MID)
            score_s = score_s - 8'sd5;

        score = score_s[7] ? 7'd0 : score_s[6:0];

        cout.motion_level  = cin.motion;
        cout.bump_level    = cin.bump;
        cout.comfort_score = 7'd0;
        cout.pet_status    = mcc_pkg::PET_UNKNOWN;
        cout.risk_level    = mcc_pkg::RISK_WARNING;
        cout.message_code  = mcc_pkg::MSG_UNAVAILABLE;

        if (cin.motion_ok && cin.env_ok)
        begin
            cout.comfort_score = score;

            if (cin.motion < CALM_MAX)
                cout.pet_status = mcc_pkg::PET_CALM;
            else if (cin.motion < MOTION_HIGH)
                cout.pet_status = mcc_pkg::PET_ACTIVE;
            else
                cout.pet_status = mcc_pkg::PET_ANXIOUS;

            if (temp_danger || score < SCORE_DANGER)
                cout.risk_level = mcc_pkg::RISK_DANGER;
            else if (temp_hot || hum_high || bump_hard || score < SCORE_WARN)
                cout.risk_level = mcc_pkg::RISK_WARNING;
            else
                cout.risk_level = mcc_pkg::RISK_NORMAL;

            if (cout.risk_level == mcc_pkg::RISK_DANGER && temp_danger)
                cout.message_code = mcc_pkg::MSG_TEMP_UNSAFE;
            else if (cout.risk_level == mcc_pkg::RISK_WARNING && temp_hot)
                cout.message_code = mcc_pkg::MSG_TEMP_HIGH;
            else if (cout.risk_level == mcc_pkg::RISK_WARNING && bump_hard)
                cout.message_code = mcc_pkg::MSG_BUMPS;
            else if (cin.motion > MOTION_HIGH)
                cout.message_code = mcc_pkg::MSG_ACTIVITY;
            else
                cout.message_code = mcc_pkg::MSG_COMFORTABLE;
        end
    end

endmodule

[hdl/motion_comfort_classifier_unit.sv]
// Sample item without burst end: squares of the three axes, square root, then delta update.
// Burst end adds two 11-step restoring divisions (skipped when a difference is zero or
// saturates) plus any wait for a held result; one item at a time.
// The sequencer shares one multiplier/subtractor: three squares, the
// 2-bit-per-cycle square root and the 1-bit-per-cycle level divisions.
// rst_n (async, active low) clears the sequencer, history and scales to defaults.
module motion_comfort_classifier_unit #(
    parameter int AXIS_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    mcc_sample_if.sink         sample,
    mcc_result_if.source       result,
    mcc_cfg_if.sink            cfg
);

    // Magnitude datapath widths follow the axis width.
    localparam int MAG_W      = AXIS_BITS;
    localparam int SUM_W      = 2 * AXIS_BITS + 2;   // sum of three squares
    localparam int SQRT_STEPS = SUM_W / 2;           // two radicand bits per step
    localparam int REM_W      = AXIS_BITS + 2;       // square root remainder
    localparam int NUM_W      = AXIS_BITS + 10;      // difference * 1000
    localparam int STEPS_MAX  = (SQRT_STEPS > mcc_pkg::QUO_W) ? SQRT_STEPS
                                                              : mcc_pkg::QUO_W;
    localparam int CNT_W      = $clog2(STEPS_MAX + 1);

    // Divide by 10 as multiply by reciprocal; exact for sums up to 10000.
    localparam int SMOOTH_W    = 14;
    localparam int DIV10_SHIFT = 19;
    localparam logic [mcc_pkg::MUL_W-1:0] DIV10_RECIP = 16'd52429;
    localparam logic [mcc_pkg::MUL_W-1:0] LVL_MULT    = 16'd1000;

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    mcc_pkg::state_t    state_reg, state_next;
    mcc_pkg::in_item_t  item_reg, item_next;
    mcc_pkg::out_item_t out_reg, out_next;
    logic               out_valid_reg, out_valid_next;

    logic [mcc_pkg::SCALE_W-1:0] mscale_reg, mscale_next;
    logic [mcc_pkg::SCALE_W-1:0] bscale_reg, bscale_next;

    // history: magnitude and smoothing survive across bursts, peak and last delta are per burst
    logic [MAG_W-1:0]          prev_reg, prev_next;
    logic                      seen_reg, seen_next;
    logic [mcc_pkg::LVL_W-1:0] smooth_reg, smooth_next;
    logic [MAG_W-1:0]          peak_reg, peak_next;
    logic [MAG_W-1:0]          last_reg, last_next;

    // working registers of the sequencer
    logic [SUM_W-1:0]          sum_reg, sum_next;
    logic [REM_W-1:0]          rem_reg, rem_next;
    logic [MAG_W-1:0]          root_reg, root_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic [NUM_W-1:0]          num_reg, num_next;
    logic [mcc_pkg::SUB_W-1:0] den_reg, den_next;
    logic [mcc_pkg::QUO_W-1:0] quo_reg, quo_next;
    logic                      sel_reg, sel_next;      // 0 motion, 1 bump
    logic [mcc_pkg::LVL_W-1:0] motion_lvl_reg, motion_lvl_next;
    logic [mcc_pkg::LVL_W-1:0] bump_lvl_reg, bump_lvl_next;

    // ---------------------------------------------------------------
    // Combinational helpers
    // ---------------------------------------------------------------
    mcc_pkg::alu_req_t  alu_req;
    mcc_pkg::alu_res_t  alu_res;
    mcc_pkg::cls_in_t   cls_in;
    mcc_pkg::out_item_t cls_out;

    logic [AXIS_BITS-1:0]      axis_raw;
    logic [AXIS_BITS-1:0]      axis_abs;
    logic [REM_W-1:0]          rem_in;
    logic [REM_W-1:0]          trial;
    logic                      mag_ge;
    logic [MAG_W-1:0]          delta;
    logic [MAG_W-1:0]          lv_diff;
    logic [mcc_pkg::SCALE_W-1:0] lv_scale;
    logic [mcc_pkg::LVL_W-1:0] quo_sat;
    logic [SMOOTH_W-1:0]       smooth_sum;
    logic                      out_free;

    mcc_alu u_alu (
        .req (alu_req),
        .res (alu_res)
    );

    mcc_classify u_classify (
        .cin  (cls_in),
        .cout (cls_out)
    );

    assign sample.ready = (state_reg == mcc_pkg::ST_IDLE);
    assign result.valid = out_valid_reg;
    assign result.data  = out_reg;
    assign cfg.ready    = 1'b1;
    assign out_free     = ~out_valid_reg | result.ready;

    always_comb
    begin
        cls_in.motion_ok   = item_reg.motion_ok;
        cls_in.env_ok      = item_reg.env_ok;
        cls_in.temperature = item_reg.temperature;
        cls_in.humidity    = item_reg.humidity;
        cls_in.motion      = motion_lvl_reg;
        cls_in.bump        = bump_lvl_reg;
    end

    // axis feeding the squarer; only the low AXIS_BITS bits count
    always_comb
    begin
        case (state_reg)
            mcc_pkg::ST_SQ_Y: axis_raw = item_reg.accel_y[AXIS_BITS-1:0];
            mcc_pkg::ST_SQ_Z: axis_raw = item_reg.accel_z[AXIS_BITS-1:0];
            default:          axis_raw = item_reg.accel_x[AXIS_BITS-1:0];
        endcase
        axis_abs = axis_raw[AXIS_BITS-1] ? (~axis_raw + 1'b1) : axis_raw;
    end

    always_comb
    begin
        // digit-by-digit root: bring in two radicand bits, try 4*root+1
        rem_in   = {rem_reg[REM_W-3:0], sum_reg[SUM_W-1 -: 2]};
        trial    = {root_reg, 2'b01};
        mag_ge   = root_reg >= prev_reg;
        delta    = mag_ge ? (root_reg - prev_reg) : (prev_reg - root_reg);
        lv_diff  = sel_reg ? peak_reg : last_reg;
        lv_scale = sel_reg ? bscale_reg : mscale_reg;
        quo_sat  = (quo_reg > mcc_pkg::QUO_W'(mcc_pkg::LVL_MAX)) ? mcc_pkg::LVL_MAX
                                                                 : quo_reg[mcc_pkg::LVL_W-1:0];
        // 7*old + 3*new
        smooth_sum = SMOOTH_W'({smooth_reg, 3'b000}) - SMOOTH_W'(smooth_reg)
                   + SMOOTH_W'({motion_lvl_reg, 1'b0}) + SMOOTH_W'(motion_lvl_reg);
    end

    // ---------------------------------------------------------------
    // Sequencer: next state, ALU operand steering, register updates
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next      = state_reg;
        item_next       = item_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        mscale_next     = mscale_reg;
        bscale_next     = bscale_reg;
        prev_next       = prev_reg;
        seen_next       = seen_reg;
        smooth_next     = smooth_reg;
        peak_next       = peak_reg;
        last_next       = last_reg;
        sum_next        = sum_reg;
        rem_next        = rem_reg;
        root_next       = root_reg;
        cnt_next        = cnt_reg;
        num_next        = num_reg;
        den_next        = den_reg;
        quo_next        = quo_reg;
        sel_next        = sel_reg;
        motion_lvl_next = motion_lvl_reg;
        bump_lvl_next   = bump_lvl_reg;
        alu_req         = '0;

        if (cfg.valid)
        begin
            unique case (mcc_pkg::cfg_reg_t'(cfg.index))
                mcc_pkg::REG_MOTION_SCALE: mscale_next = cfg.data;
                mcc_pkg::REG_BUMP_SCALE:   bscale_next = cfg.data;
            endcase
        end

        if (result.ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            mcc_pkg::ST_IDLE:
            begin
                if (sample.valid)
                begin
                    item_next = sample.data;
                    if (sample.data.sample_valid)
                        state_next = mcc_pkg::ST_SQ_X;
                    else if (sample.data.burst_end)
                        state_next = mcc_pkg::ST_CLOSE;
                end
            end

            mcc_pkg::ST_SQ_X:
            begin
                alu_req.mul_a = mcc_pkg::MUL_W'(axis_abs);
                alu_req.mul_b = mcc_pkg::MUL_W'(axis_abs);
                sum_next      = SUM_W'(alu_res.prod);
                state_next    = mcc_pkg::ST_SQ_Y;
            end

            mcc_pkg::ST_SQ_Y:
            begin
                alu_req.mul_a = mcc_pkg::MUL_W'(axis_abs);
                alu_req.mul_b = mcc_pkg::MUL_W'(axis_abs);
                sum_next      = sum_reg + SUM_W'(alu_res.prod);
                state_next    = mcc_pkg::ST_SQ_Z;
            end

            mcc_pkg::ST_SQ_Z:
            begin
                alu_req.mul_a = mcc_pkg::MUL_W'(axis_abs);
                alu_req.mul_b = mcc_pkg::MUL_W'(axis_abs);
                sum_next      = sum_reg + SUM_W'(alu_res.prod);
                rem_next      = '0;
                root_next     = '0;
                cnt_next      = CNT_W'(SQRT_STEPS);
                state_next    = mcc_pkg::ST_SQRT;
            end

            mcc_pkg::ST_SQRT:
            begin
                alu_req.sub_a = mcc_pkg::SUB_W'(rem_in);
                alu_req.sub_b = mcc_pkg::SUB_W'(trial);
                sum_next      = sum_reg << 2;
                if (alu_res.ge)
                begin
                    rem_next  = alu_res.diff[REM_W-1:0];
                    root_next = {root_reg[MAG_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = rem_in;
                    root_next = {root_reg[MAG_W-2:0], 1'b0};
                end
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                    state_next = mcc_pkg::ST_DELTA;
            end

            mcc_pkg::ST_DELTA:
            begin
                // first magnitude after reset is only stored
                if (seen_reg)
                begin
                    last_next = delta;
                    if (delta > peak_reg)
                        peak_next = delta;
                end
                prev_next  = root_reg;
                seen_next  = 1'b1;
                state_next = item_reg.burst_end ? mcc_pkg::ST_CLOSE : mcc_pkg::ST_IDLE;
            end

            mcc_pkg::ST_CLOSE:
            begin
                if (item_reg.motion_ok)
                begin
                    sel_next   = 1'b0;
                    state_next = mcc_pkg::ST_LV_MUL;
                end
                else
                begin
                    // sensor missing: levels read zero, smoothing untouched
                    motion_lvl_next = '0;
                    bump_lvl_next   = '0;
                    state_next      = mcc_pkg::ST_FINISH;
                end
            end

            mcc_pkg::ST_LV_MUL:
            begin
                alu_req.mul_a = mcc_pkg::MUL_W'(lv_diff);
                alu_req.mul_b = LVL_MULT;
                num_next      = alu_res.prod[NUM_W-1:0];
                state_next    = mcc_pkg::ST_LV_PRE;
            end

            mcc_pkg::ST_LV_PRE:
            begin
                // quotient >= 2048 (or zero scale with a nonzero difference) saturates outright
                alu_req.sub_a = mcc_pkg::SUB_W'(num_reg);
                alu_req.sub_b = mcc_pkg::SUB_W'(lv_scale) << mcc_pkg::QUO_W;
                quo_next      = '0;
                if (lv_diff == '0)
                    state_next = mcc_pkg::ST_LV_DONE;
                else if (alu_res.ge)
                begin
                    quo_next   = mcc_pkg::QUO_W'(mcc_pkg::LVL_MAX);
                    state_next = mcc_pkg::ST_LV_DONE;
                end
                else
                begin
                    den_next   = mcc_pkg::SUB_W'(lv_scale) << (mcc_pkg::QUO_W - 1);
                    cnt_next   = CNT_W'(mcc_pkg::QUO_W);
                    state_next = mcc_pkg::ST_LV_DIV;
                end
            end

            mcc_pkg::ST_LV_DIV:
            begin
                // restoring division, one quotient bit per cycle
                alu_req.sub_a = mcc_pkg::SUB_W'(num_reg);
                alu_req.sub_b = den_reg;
                if (alu_res.ge)
                    num_next = alu_res.diff[NUM_W-1:0];
                quo_next = {quo_reg[mcc_pkg::QUO_W-2:0], alu_res.ge};
                den_next = den_reg >> 1;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                    state_next = mcc_pkg::ST_LV_DONE;
            end

            mcc_pkg::ST_LV_DONE:
            begin
                if (sel_reg)
                begin
                    bump_lvl_next = quo_sat;
                    state_next    = mcc_pkg::ST_FINISH;
                end
                else
                begin
                    motion_lvl_next = quo_sat;
                    state_next      = mcc_pkg::ST_SMOOTH;
                end
            end

            mcc_pkg::ST_SMOOTH:
            begin
                alu_req.mul_a   = mcc_pkg::MUL_W'(smooth_sum);
                alu_req.mul_b   = DIV10_RECIP;
                smooth_next     = alu_res.prod[DIV10_SHIFT +: mcc_pkg::LVL_W];
                motion_lvl_next = alu_res.prod[DIV10_SHIFT +: mcc_pkg::LVL_W];
                sel_next        = 1'b1;
                state_next      = mcc_pkg::ST_LV_MUL;
            end

            mcc_pkg::ST_FINISH:
            begin
                // wait for the output register to free up
                if (out_free)
                begin
                    out_next       = cls_out;
                    out_valid_next = 1'b1;
                    last_next      = '0;
                    peak_next      = '0;
                    state_next     = mcc_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = mcc_pkg::ST_IDLE;
            end
        endcase
    end

    // control and persistent state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mcc_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            mscale_reg    <= mcc_pkg::MOTION_SCALE_RST;
            bscale_reg    <= mcc_pkg::BUMP_SCALE_RST;
            prev_reg      <= '0;
            seen_reg      <= 1'b0;
            smooth_reg    <= '0;
            peak_reg      <= '0;
            last_reg      <= '0;
            cnt_reg       <= '0;
            sel_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            mscale_reg    <= mscale_next;
            bscale_reg    <= bscale_next;
            prev_reg      <= prev_next;
            seen_reg      <= seen_next;
            smooth_reg    <= smooth_next;
            peak_reg      <= peak_next;
            last_reg      <= last_next;
            cnt_reg       <= cnt_next;
            sel_reg       <= sel_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        item_reg       <= item_next;
        out_reg        <= out_next;
        sum_reg        <= sum_next;
        rem_reg        <= rem_next;
        root_reg       <= root_next;
        num_reg        <= num_next;
        den_reg        <= den_next;
        quo_reg        <= quo_next;
        motion_lvl_reg <= motion_lvl_next;
        bump_lvl_reg   <= bump_lvl_next;
    end

endmodule

[bench/motion_comfort_classifier_unit_test.sv]
`timescale 1ns / 100ps

module motion_comfort_classifier_unit_test;

    import mcc_pkg::*;

    // The block holds one item in work at a time.
    localparam int          SETTLE_CYCLES = 64;
    localparam int          HOLD_CYCLES   = 400;
    localparam int          PHASE_ITEMS   = 400;
    localparam int          CYCLE_LIMIT   = 1_000_000;
    localparam int unsigned FULL_SWING    = 70000;

    typedef enum logic { ROW_ITEM, ROW_CFG } row_kind_t;

    // One line of the directed table: an item (result optionally typed in)
    // or a scale register write.
    typedef struct {
        row_kind_t   kind;
        in_item_t    item;
        bit          pinned;
        out_item_t   want;
        cfg_reg_t    reg_idx;
        logic [15:0] reg_val;
    } row_t;

    typedef struct {
        bit        pinned;
        out_item_t want;
    } pin_t;

    logic clk = 1'b0;
    logic rst_n;

    mcc_sample_if sample_ch ();
    mcc_result_if result_ch ();
    mcc_cfg_if    cfg_ch ();

    motion_comfort_classifier_unit #(
        .AXIS_BITS (16)
    ) i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Classifier prediction: own copy of history and scales
    // ------------------------------------------------------------------
    int unsigned last_mag;
    bit          have_mag;
    int unsigned motion_avg;
    int unsigned peak_delta;
    int unsigned last_delta;
    int unsigned motion_div;
    int unsigned bump_div;

    out_item_t pending_reports[$];  // expected classification results, oldest first
    pin_t      pinned_reports[$];   // one per item offered, typed-in results
    row_t      plan[$];

    int report_errors;
    int send_idle_pct;
    int recv_idle_pct;
    bit hold_off_req;
    bit hold_off_taken;
    int cycle_count;

    // Difference to thousandths; zero divisor saturates any nonzero difference.
    function automatic int unsigned scale_level(input int unsigned diff, input int unsigned div);
        int unsigned q;
        if (div == 0)
            return (diff != 0) ? 1000 : 0;
        q = (diff * 1000) / div;
        return (q > 1000) ? 1000 : q;
    endfunction

    function automatic bit classify_step(input in_item_t it, output out_item_t res);
        longint          ax;
        longint          ay;
        longint          az;
        longint unsigned energy;
        int unsigned     root;
        int unsigned     trial;
        int unsigned     d;
        int unsigned     mot;
        int unsigned     bmp;
        int              tc;
        int              hc;
        int              s;
        res = '0;
        res.risk_level = RISK_WARNING;
        if (it.sample_valid)
        begin
            ax = $signed(it.accel_x);
            ay = $signed(it.accel_y);
            az = $signed(it.accel_z);
            energy = ax * ax + ay * ay + az * az;
            // floor square root, one result bit at a time from the top
            root = 0;
            for (int b = 16; b >= 0; b--)
            begin
                trial = root | (32'd1 << b);
                if (64'(trial) * 64'(trial) <= energy)
                    root = trial;
            end
            root = root & 32'hFFFF;
            if (have_mag)
            begin
                d = (root > last_mag) ? root - last_mag : last_mag - root;
                last_delta = d;
                if (d > peak_delta)
                    peak_delta = d;
            end
            last_mag = root;
            have_mag = 1'b1;
        end
        if (!it.burst_end)
            return 1'b0;

        mot = 0;
        bmp = 0;
        if (it.motion_ok)
        begin
            motion_avg = (7 * motion_avg + 3 * scale_level(last_delta, motion_div)) / 10;
            mot = motion_avg;
            bmp = scale_level(peak_delta, bump_div);
        end
        // burst history cleared whether or not the sensor is there
        last_delta = 0;
        peak_delta = 0;
        res.motion_level = 10'(mot);
        res.bump_level = 10'(bmp);

        if (it.motion_ok && it.env_ok)
        begin
            tc = $signed(it.temperature);
            hc = int'(it.humidity);
            s = 100;
            if (tc > 340)
                s -= 45;
            else if (tc >= 300)
                s -= 25;
            else if (tc >= 260)
                s -= 10;
            else if (tc < 100)
                s -= 30;
            else if (tc < 180)
                s -= 10;
            if (hc > 750)
                s -= 20;
            else if (hc > 650)
                s -= 10;
            else if (hc < 300)
                s -= 10;
            if (bmp > 550)
                s -= 25;
            else if (bmp >= 250)
                s -= 10;
            if (mot > 600)
                s -= 15;
            else if (mot >= 300)
                s -= 5;
            if (s < 0)
                s = 0;
            res.comfort_score = 7'(s);

            if (mot < 250)
                res.pet_status = PET_CALM;
            else if (mot < 600)
                res.pet_status = PET_ACTIVE;
            else
                res.pet_status = PET_ANXIOUS;

            if (tc > 340 || s < 50)
                res.risk_level = RISK_DANGER;
            else if (tc > 300 || hc > 750 || bmp > 550 || s < 70)
                res.risk_level = RISK_WARNING;
            else
                res.risk_level = RISK_NORMAL;

            if (res.risk_level == RISK_DANGER && tc > 340)
                res.message_code = MSG_TEMP_UNSAFE;
            else if (res.risk_level == RISK_WARNING && tc > 300)
                res.message_code = MSG_TEMP_HIGH;
            else if (res.risk_level == RISK_WARNING && bmp > 550)
                res.message_code = MSG_BUMPS;
            else if (mot > 600)
                res.message_code = MSG_ACTIVITY;
            else
                res.message_code = MSG_COMFORTABLE;
        end
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Scoreboard: results checked before new items are predicted
    // ------------------------------------------------------------------
    task automatic check_report(input out_item_t got);
        out_item_t want;
        if (pending_reports.size() == 0)
        begin
            report_errors++;
            if (report_errors <= 10)
                $display("[%0t] result with nothing pending: mot=%0d bump=%0d score=%0d pet=%0d risk=%0d msg=%0d",
                         $time, got.motion_level, got.bump_level, got.comfort_score,
                         got.pet_status, got.risk_level, got.message_code);
            return;
        end
        want = pending_reports.pop_front();
        if (got.motion_level !== want.motion_level || got.bump_level !== want.bump_level
            || got.comfort_score !== want.comfort_score || got.pet_status !== want.pet_status
            || got.risk_level !== want.risk_level || got.message_code !== want.message_code)
        begin
            report_errors++;
            // field order: motion, bump, score, pet, risk, message
            if (report_errors <= 10)
                $display("[%0t] result mismatch: expected %0d/%0d/%0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d/%0d/%0d",
                         $time, want.motion_level, want.bump_level, want.comfort_score,
                         want.pet_status, want.risk_level, want.message_code,
                         got.motion_level, got.bump_level, got.comfort_score,
                         got.pet_status, got.risk_level, got.message_code);
        end
    endtask

    always @(posedge clk)
    begin
        pin_t      pin;
        out_item_t predicted;
        if (rst_n)
        begin
            if (result_ch.valid && result_ch.ready)
                check_report(result_ch.data);
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                case (cfg_reg_t'(cfg_ch.index))
                    REG_MOTION_SCALE: motion_div = cfg_ch.data;
                    REG_BUMP_SCALE:   bump_div = cfg_ch.data;
                    default:          ;
                endcase
            end
            if (sample_ch.valid && sample_ch.ready)
            begin
                pin = pinned_reports.pop_front();
                if (classify_step(sample_ch.data, predicted))
                    pending_reports.push_back(pin.pinned ? pin.want : predicted);
            end
        end
    end

    // ------------------------------------------------------------------
    // Result side: random back-pressure, plus one long hold-off on request
    // ------------------------------------------------------------------
    initial
    begin
        result_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off_req && !hold_off_taken)
            begin
                hold_off_taken = 1'b1;
                result_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic in_item_t item_of(input bit sv, input int x, input int y, input int z,
                                         input bit be, input bit mok, input bit eok,
                                         input int t, input int h);
        in_item_t it;
        it.sample_valid = sv;
        it.accel_x = 16'(x);
        it.accel_y = 16'(y);
        it.accel_z = 16'(z);
        it.burst_end = be;
        it.motion_ok = mok;
        it.env_ok = eok;
        it.temperature = 12'(t);
        it.humidity = 10'(h);
        return it;
    endfunction

    function automatic row_t row_item(input in_item_t it);
        row_t r;
        r = '{kind: ROW_ITEM, item: it, pinned: 1'b0, want: '0,
              reg_idx: REG_MOTION_SCALE, reg_val: '0};
        return r;
    endfunction

    function automatic row_t row_pinned(input in_item_t it, input int mot, input int bmp,
                                        input int score, input pet_t p, input risk_t rk,
                                        input msg_t m);
        row_t r;
        r = row_item(it);
        r.pinned = 1'b1;
        r.want.motion_level = 10'(mot);
        r.want.bump_level = 10'(bmp);
        r.want.comfort_score = 7'(score);
        r.want.pet_status = p;
        r.want.risk_level = rk;
        r.want.message_code = m;
        return r;
    endfunction

    function automatic row_t row_cfg(input cfg_reg_t idx, input int val);
        row_t r;
        r = row_item('0);
        r.kind = ROW_CFG;
        r.reg_idx = idx;
        r.reg_val = 16'(val);
        return r;
    endfunction

    // One transfer on the sample channel; valid stays high into the next item
    // unless a gap is drawn.
    task automatic offer(input in_item_t it, input bit pinned, input out_item_t want);
        int gap;
        pin_t pin;
        pin.pinned = pinned;
        pin.want = want;
        pinned_reports.push_back(pin);
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
            gap++;
        if (gap != 0)
        begin
            sample_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_ch.valid <= 1'b1;
        sample_ch.data <= it;
        @(posedge clk);
        while (!sample_ch.ready)
            @(posedge clk);
    endtask

    // Drop valid, drain all pending results, then let a sample item finish.
    task automatic settle();
        sample_ch.valid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [15:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= val;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [15:0] axis_value(input int base, input int unsigned amp);
        if (amp == FULL_SWING)
            return 16'($urandom);
        return 16'(base + int'($urandom_range(2 * amp)) - int'(amp));
    endfunction

    // Mostly lands near a comfort threshold or in range; sometimes any code.
    function automatic int pick_temperature();
        int m;
        case ($urandom_range(7))
            0: return int'($urandom_range(4095));
            1, 2, 3:
            begin
                case ($urandom_range(4))
                    0:       m = 100;
                    1:       m = 180;
                    2:       m = 260;
                    3:       m = 300;
                    default: m = 340;
                endcase
                return m + int'($urandom_range(4)) - 2;
            end
            default: return int'($urandom_range(1650)) - 400;
        endcase
    endfunction

    function automatic int pick_humidity();
        int m;
        case ($urandom_range(7))
            0: return int'($urandom_range(1023));
            1, 2, 3:
            begin
                case ($urandom_range(2))
                    0:       m = 300;
                    1:       m = 650;
                    default: m = 750;
                endcase
                return m + int'($urandom_range(4)) - 2;
            end
            default: return int'($urandom_range(1000));
        endcase
    endfunction

    // Bursts of samples around a random resting vector, closed by a burst end.
    // Swing per burst ranges from none to full scale; ignored items sprinkled in.
    task automatic run_bursts(input int n_items);
        int          sent;
        int          len;
        int unsigned amp;
        int          bx;
        int          by;
        int          bz;
        in_item_t    it;
        sent = 0;
        while (sent < n_items)
        begin
            bx = int'($urandom_range(32767)) - 16384;
            by = int'($urandom_range(32767)) - 16384;
            bz = int'($urandom_range(32767)) - 16384;
            case ($urandom_range(5))
                0:       amp = 0;
                1:       amp = 12;
                2:       amp = 300;
                3:       amp = 1500;
                4:       amp = 6000;
                default: amp = FULL_SWING;
            endcase
            len = $urandom_range(6);
            for (int k = 0; k <= len; k++)
            begin
                if ($urandom_range(9) == 0)
                begin
                    // no sample, no burst end: block ignores it
                    it = item_of(1'b0, $urandom, $urandom, $urandom, 1'b0, $urandom_range(1),
                                 $urandom_range(1), $urandom, $urandom);
                    offer(it, 1'b0, '0);
                end
                it = item_of(1'b1, axis_value(bx, amp), axis_value(by, amp),
                             axis_value(bz, amp), 1'b0, $urandom_range(1),
                             $urandom_range(1), $urandom, $urandom);
                // last pass closes the burst, sometimes carrying a sample too
                if (k == len)
                begin
                    it.sample_valid = $urandom_range(1);
                    it.burst_end = 1'b1;
                    it.motion_ok = ($urandom_range(9) != 0);
                    it.env_ok = ($urandom_range(7) != 0);
                    it.temperature = 12'(pick_temperature());
                    it.humidity = 10'(pick_humidity());
                end
                offer(it, 1'b0, '0);
                sent++;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Run limit
    // ------------------------------------------------------------------
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("** motion_comfort_classifier_unit: FAILED **");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n <= 1'b0;
        sample_ch.valid <= 1'b0;
        sample_ch.data <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= REG_MOTION_SCALE;
        cfg_ch.data <= '0;
        last_mag = 0;
        have_mag = 1'b0;
        motion_avg = 0;
        peak_delta = 0;
        last_delta = 0;
        motion_div = MOTION_SCALE_RST;
        bump_div = BUMP_SCALE_RST;
        report_errors = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_off_req = 1'b0;
        hold_off_taken = 1'b0;

        // Directed table. Fresh from reset the first three results are fixed.
        plan.push_back(row_pinned(item_of(0, 0, 0, 0, 1, 1, 1, 220, 500),
                                  0, 0, 100, PET_CALM, RISK_NORMAL, MSG_COMFORTABLE));
        // sensor faults
        plan.push_back(row_pinned(item_of(0, 0, 0, 0, 1, 0, 1, 220, 500),
                                  0, 0, 0, PET_UNKNOWN, RISK_WARNING, MSG_UNAVAILABLE));
        plan.push_back(row_pinned(item_of(0, 0, 0, 0, 1, 1, 0, 220, 500),
                                  0, 0, 0, PET_UNKNOWN, RISK_WARNING, MSG_UNAVAILABLE));
        // first magnitude only stored; axis extremes; out-of-range temp/humidity
        plan.push_back(row_item(item_of(1, -32768, -32768, -32768, 0, 1, 1, 0, 0)));
        plan.push_back(row_item(item_of(1, 32767, 32767, 32767, 1, 1, 1, 2047, 1023)));
        plan.push_back(row_item(item_of(1, 0, 0, 0, 0, 1, 1, 0, 0)));
        // sample and burst end together; peak kept from earlier sample
        plan.push_back(row_item(item_of(1, 0, 0, 0, 1, 1, 1, -2048, 0)));
        plan.push_back(row_item(item_of(1, 32767, 0, 0, 1, 1, 1, 350, 700)));
        // bare burst end after a close: deltas back to zero
        plan.push_back(row_item(item_of(0, 0, 0, 0, 1, 1, 1, 320, 500)));
        // motion sensor missing with deltas pending: smoothing must hold
        plan.push_back(row_item(item_of(1, 0, 0, 0, 0, 1, 1, 0, 0)));
        plan.push_back(row_item(item_of(0, 0, 0, 0, 1, 0, 1, 220, 500)));
        // environment invalid: levels still reported, smoothing advances
        plan.push_back(row_item(item_of(1, 0, 16384, 0, 0, 1, 1, 0, 0)));
        plan.push_back(row_item(item_of(0, 0, 0, 0, 1, 1, 0, 220, 500)));
        plan.push_back(row_item(item_of(1, 0, 0, -16384, 0, 1, 1, 0, 0)));
        plan.push_back(row_item(item_of(1, 0, 0, -26000, 1, 1, 1, 220, 500)));
        // zero divisors
        plan.push_back(row_cfg(REG_MOTION_SCALE, 0));
        plan.push_back(row_cfg(REG_BUMP_SCALE, 0));
        plan.push_back(row_item(item_of(0, 0, 0, 0, 1, 1, 1, 220, 500)));
        plan.push_back(row_item(item_of(1, 5, 0, 0, 1, 1, 1, 220, 500)));
        plan.push_back(row_item(item_of(1, 5, 0, 0, 1, 1, 1, 220, 500)));
        // tiny motion divisor, huge bump divisor: motion climbs to anxious
        plan.push_back(row_cfg(REG_MOTION_SCALE, 1));
        plan.push_back(row_cfg(REG_BUMP_SCALE, 65535));
        plan.push_back(row_item(item_of(1, 20000, 0, 0, 1, 1, 1, 220, 500)));
        plan.push_back(row_item(item_of(1, 0, 0, 0, 1, 1, 1, 220, 500)));
        plan.push_back(row_item(item_of(1, 20000, 0, 0, 1, 1, 1, 220, 500)));
        plan.push_back(row_item(item_of(1, -1, -1, -1, 1, 1, 1, -400, 1000)));
        // and the other way round
        plan.push_back(row_cfg(REG_MOTION_SCALE, 65535));
        plan.push_back(row_cfg(REG_BUMP_SCALE, 1));
        plan.push_back(row_item(item_of(1, -32768, 0, 0, 1, 1, 1, 1250, 0)));
        plan.push_back(row_item(item_of(1, 12345, -12345, 100, 1, 1, 1, 260, 650)));
        plan.push_back(row_item(item_of(1, 0, 0, 0, 1, 1, 1, 180, 751)));

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_CFG)
            begin
                settle();
                write_reg(plan[i].reg_idx, plan[i].reg_val);
            end
            else
                offer(plan[i].item, plan[i].pinned, plan[i].want);
        end

        // Phase 1: sender mostly busy, receiver often stalled.
        settle();
        write_reg(REG_MOTION_SCALE, 16'd2000);
        write_reg(REG_BUMP_SCALE, 16'd9000);
        send_idle_pct = 10;
        recv_idle_pct = 67;
        run_bursts(PHASE_ITEMS);

        // Phase 2: roles swapped, random divisors.
        settle();
        write_reg(REG_MOTION_SCALE, 16'($urandom_range(12000, 500)));
        write_reg(REG_BUMP_SCALE, 16'($urandom_range(12000, 500)));
        send_idle_pct = 67;
        recv_idle_pct = 10;
        run_bursts(PHASE_ITEMS);

        // Phase 3: full rate, reset divisors, one long result hold-off up front
        // so the block backs up into the sample channel.
        settle();
        write_reg(REG_MOTION_SCALE, MOTION_SCALE_RST);
        write_reg(REG_BUMP_SCALE, BUMP_SCALE_RST);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_off_req = 1'b1;
        run_bursts(PHASE_ITEMS);

        settle();
        if (report_errors == 0 && pending_reports.size() == 0)
            $display("** motion_comfort_classifier_unit: PASSED **");
        else
            $display("** motion_comfort_classifier_unit: FAILED **");
        $finish;
    end

endmodule

[filelist.f]
hdl/mcc_pkg.sv
hdl/mcc_if.sv
hdl/mcc_alu.sv
hdl/mcc_classify.sv
hdl/motion_comfort_classifier_unit.sv
bench/motion_comfort_classifier_unit_test.sv
